/* hdl/esl_pkg.sv */
// Shared constants and curve codes for the envelope segment level block.
package esl_pkg;

    localparam int LEVEL_WIDTH_DEF = 16;
    localparam int TICK_WIDTH_DEF  = 16;

    localparam int CURVE_WIDTH = 2;

    localparam logic [CURVE_WIDTH-1:0] CURVE_LINEAR = 2'd0;
    localparam logic [CURVE_WIDTH-1:0] CURVE_EXP    = 2'd1;
    localparam logic [CURVE_WIDTH-1:0] CURVE_LOG    = 2'd2;

endpackage

/* hdl/envelope_segment_level.sv */
// Envelope segment level: pipelined interpolation of one envelope point per word.
//
// Each input word carries a start level, an end level, a segment length n in
// ticks, a tick position k and a curve code, and produces one output word: the
// level at that tick, start + (end - start) * fraction, where the fraction is
// k/n (linear), (n*n - (n-k)*(n-k)) / (n*n) (exponential, fast start) or
// k*k / (n*n) (logarithmic, slow start); code 3 behaves as linear. The
// quotient is exact and rounded half away from zero. A zero-length segment
// returns the end level, and a position past the end is clamped to the end.
// The block is a fully pipelined datapath that takes one word in every clock
// cycle while the skid register is free. Five front stages handle the clamp
// and level difference, the squaring multipliers, the curve select, the
// level-by-fraction multiplier and the rounding add; then a restoring divider
// with one stage per quotient bit (LEVEL_WIDTH stages) produces the magnitude
// of the step from the start level. Since the quotient can never exceed the
// level difference, LEVEL_WIDTH quotient bits cover every case. The output
// side has a two-entry buffer (output register plus skid register), so the
// input keeps accepting while a finished word waits; in_ready only drops
// once the skid register is occupied, and it is driven straight from a flop.
module envelope_segment_level
    import esl_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF,
    parameter int TICK_WIDTH  = TICK_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [LEVEL_WIDTH-1:0] start_level,
    input  logic signed [LEVEL_WIDTH-1:0] end_level,
    input  logic        [TICK_WIDTH-1:0]  segment_ticks,
    input  logic        [TICK_WIDTH-1:0]  tick_position,
    input  logic        [CURVE_WIDTH-1:0] curve_kind,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [LEVEL_WIDTH-1:0] level_out
);

    localparam int LW     = LEVEL_WIDTH;
    localparam int TW     = TICK_WIDTH;
    localparam int DW     = LW + 1;          // level difference, signed
    localparam int SQW    = 2 * TW;          // squared tick values
    localparam int PW     = LW + SQW;        // |difference| * numerator
    localparam int DVW    = PW + 1;          // rounded dividend
    localparam int D2W    = SQW + 1;         // doubled denominator
    localparam int NFRONT = 5;
    localparam int NPIPE  = NFRONT + LW;

    // Valid bits travel alongside the data; the whole pipe shifts together
    // whenever the skid register is free.
    logic [NPIPE-1:0] vld_reg;
    logic             skid_valid_reg;
    logic             out_valid_reg;
    logic             adv;

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: clamp the position, take the level difference apart into
    // sign and magnitude. A zero-length segment is rewritten as a one-tick
    // segment from the end level to itself, so the rest of the pipe needs
    // no special case.
    // ------------------------------------------------------------------
    logic [TW:0]    diff_nk;
    logic           borrow;
    logic           zero_len;
    logic [DW-1:0]  d_fwd;
    logic [DW-1:0]  d_rev;

    assign diff_nk  = {1'b0, segment_ticks} - {1'b0, tick_position};
    assign borrow   = diff_nk[TW];
    assign zero_len = (segment_ticks == '0);
    assign d_fwd    = {end_level[LW-1], end_level} - {start_level[LW-1], start_level};
    assign d_rev    = {start_level[LW-1], start_level} - {end_level[LW-1], end_level};

    logic [LW-1:0]          from_s1_reg;
    logic [LW-1:0]          mag_s1_reg;
    logic                   neg_s1_reg;
    logic [TW-1:0]          n_s1_reg;
    logic [TW-1:0]          k_s1_reg;
    logic [TW-1:0]          rest_s1_reg;
    logic [CURVE_WIDTH-1:0] curve_s1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            curve_s1_reg <= curve_kind;
            if (zero_len)
            begin
                from_s1_reg <= end_level;
                mag_s1_reg  <= '0;
                neg_s1_reg  <= 1'b0;
                n_s1_reg    <= TW'(1);
                k_s1_reg    <= TW'(1);
                rest_s1_reg <= '0;
            end
            else
            begin
                from_s1_reg <= start_level;
                neg_s1_reg  <= d_fwd[LW];
                mag_s1_reg  <= d_fwd[LW] ? d_rev[LW-1:0] : d_fwd[LW-1:0];
                n_s1_reg    <= segment_ticks;
                k_s1_reg    <= borrow ? segment_ticks : tick_position;
                rest_s1_reg <= borrow ? '0 : diff_nk[TW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three squares.
    // ------------------------------------------------------------------
    logic [SQW-1:0]         kk_s2_reg;
    logic [SQW-1:0]         rr_s2_reg;
    logic [SQW-1:0]         nn_s2_reg;
    logic [TW-1:0]          n_s2_reg;
    logic [TW-1:0]          k_s2_reg;
    logic [LW-1:0]          from_s2_reg;
    logic [LW-1:0]          mag_s2_reg;
    logic                   neg_s2_reg;
    logic [CURVE_WIDTH-1:0] curve_s2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kk_s2_reg    <= SQW'(k_s1_reg) * SQW'(k_s1_reg);
            rr_s2_reg    <= SQW'(rest_s1_reg) * SQW'(rest_s1_reg);
            nn_s2_reg    <= SQW'(n_s1_reg) * SQW'(n_s1_reg);
            n_s2_reg     <= n_s1_reg;
            k_s2_reg     <= k_s1_reg;
            from_s2_reg  <= from_s1_reg;
            mag_s2_reg   <= mag_s1_reg;
            neg_s2_reg   <= neg_s1_reg;
            curve_s2_reg <= curve_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pick numerator and denominator for the curve.
    // ------------------------------------------------------------------
    logic [SQW-1:0] num_next;
    logic [SQW-1:0] den_next;

    always_comb
    begin
        case (curve_s2_reg)
            CURVE_EXP:
            begin
                num_next = nn_s2_reg - rr_s2_reg;
                den_next = nn_s2_reg;
            end
            CURVE_LOG:
            begin
                num_next = kk_s2_reg;
                den_next = nn_s2_reg;
            end
            default:
            begin
                num_next = SQW'(k_s2_reg);
                den_next = SQW'(n_s2_reg);
            end
        endcase
    end

    logic [SQW-1:0] num_s3_reg;
    logic [SQW-1:0] den_s3_reg;
    logic [LW-1:0]  from_s3_reg;
    logic [LW-1:0]  mag_s3_reg;
    logic           neg_s3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_s3_reg  <= num_next;
            den_s3_reg  <= den_next;
            from_s3_reg <= from_s2_reg;
            mag_s3_reg  <= mag_s2_reg;
            neg_s3_reg  <= neg_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: |difference| times numerator.
    // ------------------------------------------------------------------
    logic [PW-1:0]  prod_s4_reg;
    logic [SQW-1:0] den_s4_reg;
    logic [LW-1:0]  from_s4_reg;
    logic           neg_s4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_s4_reg <= PW'(mag_s3_reg) * PW'(num_s3_reg);
            den_s4_reg  <= den_s3_reg;
            from_s4_reg <= from_s3_reg;
            neg_s4_reg  <= neg_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: rounding offset. The step magnitude is
    // floor((2 * |d| * num + den) / (2 * den)), which never exceeds |d|.
    // ------------------------------------------------------------------
    logic [DVW-1:0] dvd_s5_reg;
    logic [D2W-1:0] d2_s5_reg;
    logic [LW-1:0]  from_s5_reg;
    logic           neg_s5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvd_s5_reg  <= {prod_s4_reg, 1'b0} + DVW'(den_s4_reg);
            d2_s5_reg   <= {den_s4_reg, 1'b0};
            from_s5_reg <= from_s4_reg;
            neg_s5_reg  <= neg_s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, most significant first.
    // ------------------------------------------------------------------
    logic [DVW-1:0] rem_reg  [LW-1];
    logic [D2W-1:0] d2_reg   [LW-1];
    logic [LW-1:0]  q_reg    [LW];
    logic [LW-1:0]  from_reg [LW];
    logic           neg_reg  [LW];

    genvar j;
    generate
        for (j = 0; j < LW; j++)
        begin : g_div
            localparam int SH = LW - 1 - j;

            logic [DVW-1:0] rem_in;
            logic [D2W-1:0] d2_in;
            logic [LW-1:0]  q_in;
            logic [LW-1:0]  from_in;
            logic           neg_in;
            logic [DVW-1:0] dsh;
            logic           hit;

            if (j == 0)
            begin : g_first
                assign rem_in  = dvd_s5_reg;
                assign d2_in   = d2_s5_reg;
                assign q_in    = '0;
                assign from_in = from_s5_reg;
                assign neg_in  = neg_s5_reg;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[j-1];
                assign d2_in   = d2_reg[j-1];
                assign q_in    = q_reg[j-1];
                assign from_in = from_reg[j-1];
                assign neg_in  = neg_reg[j-1];
            end

            assign dsh = DVW'(d2_in) << SH;
            assign hit = (rem_in >= dsh);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    q_reg[j]    <= q_in | (LW'(hit) << SH);
                    from_reg[j] <= from_in;
                    neg_reg[j]  <= neg_in;
                end
            end

            if (j < LW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[j] <= hit ? (rem_in - dsh) : rem_in;
                        d2_reg[j]  <= d2_in;
                    end
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Valid pipeline.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NPIPE-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Apply the sign and add to the start level, then buffer the word.
    // The result always lies between the two levels, so dropping the top
    // bit of the sum is exact.
    // ------------------------------------------------------------------
    logic [LW:0]   q_ext;
    logic [LW:0]   sum;
    logic [LW-1:0] res;

    assign q_ext = {1'b0, q_reg[LW-1]};
    assign sum   = {from_reg[LW-1][LW-1], from_reg[LW-1]}
                 + (neg_reg[LW-1] ? (~q_ext + 1'b1) : q_ext);
    assign res   = sum[LW-1:0];

    logic [LW-1:0] out_data_reg;
    logic [LW-1:0] skid_data_reg;
    logic          pop;
    logic          push;

    assign pop  = out_valid_reg && out_ready;
    assign push = adv && vld_reg[NPIPE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign level_out = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output is empty");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(vld_reg))
        else $error("pipeline moved while the skid register was full");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted word did not enter the first stage");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_reg[NPIPE-1]))
        else $error("output became valid with no word leaving the pipeline");

endmodule

/* test/envelope_segment_level_test.sv */
// Self-checking testbench for the envelope segment level block.
module envelope_segment_level_test
    import esl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LW = LEVEL_WIDTH_DEF;
    localparam int TW = TICK_WIDTH_DEF;

    // The final drain waits comfortably longer than a word takes to pass the
    // front stages, the divider and the output register.
    localparam int DRAIN_CYCLES = 2 * (LW + 5) + 10;

    // About 2000 words are sent in total. Under the worst phase every word
    // may wait on the sending and the receiving side, so this bound is many
    // times the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;

    localparam int PHASE_WORDS = 500;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [LW-1:0] start_level;
    logic signed [LW-1:0] end_level;
    logic        [TW-1:0] segment_ticks;
    logic        [TW-1:0] tick_position;
    logic [CURVE_WIDTH-1:0] curve_kind;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [LW-1:0] level_out;

    // Levels the block owes us, oldest first.
    logic signed [LW-1:0] expected_levels[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Chance, in percent, that the sender skips a cycle or that the
    // receiver holds off a result in a given cycle.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    envelope_segment_level uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_level   (start_level),
        .end_level     (end_level),
        .segment_ticks (segment_ticks),
        .tick_position (tick_position),
        .curve_kind    (curve_kind),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level_out     (level_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The level on the segment at the given tick. The position is clamped to
    // the length, the step from the start level is an exact quotient rounded
    // half away from zero, and a zero-length segment jumps to the end level.
    // Code 3 falls through to the linear curve.
    function automatic logic signed [LW-1:0] interpolate_level(
        input logic signed [LW-1:0] from_level,
        input logic signed [LW-1:0] to_level,
        input logic        [TW-1:0] length,
        input logic        [TW-1:0] position,
        input logic [CURVE_WIDTH-1:0] curve
    );
        longint n;
        longint k;
        longint rest;
        longint num;
        longint den;
        longint diff;
        longint step;
        longint level;
        n = length;
        k = position;
        if (n == 0)
            return to_level;
        if (k > n)
            k = n;
        rest = n - k;
        case (curve)
            CURVE_EXP:
            begin
                num = n * n - rest * rest;
                den = n * n;
            end
            CURVE_LOG:
            begin
                num = k * k;
                den = n * n;
            end
            default:
            begin
                num = k;
                den = n;
            end
        endcase
        diff = longint'(to_level) - longint'(from_level);
        // Both operands are signed, so the division truncates toward zero and
        // the added half denominator turns that into rounding away from zero.
        step = (diff * num * 2 + (diff >= 0 ? den : -den)) / (den * 2);
        level = longint'(from_level) + step;
        return level[LW-1:0];
    endfunction

    // Offers one word and returns at the edge that takes it. On entry and on
    // return the caller stands just after a rising edge, so in_valid gets a
    // single update per time step and stays high between back-to-back words.
    task automatic send_word(
        input logic signed [LW-1:0] from_level,
        input logic signed [LW-1:0] to_level,
        input logic        [TW-1:0] length,
        input logic        [TW-1:0] position,
        input logic [CURVE_WIDTH-1:0] curve
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_level   <= from_level;
        end_level     <= to_level;
        segment_ticks <= length;
        tick_position <= position;
        curve_kind    <= curve;
        // in_ready as read here still holds its value from before the edge.
        do
            @(posedge clk);
        while (!in_ready);
        expected_levels.insert(expected_levels.size(),
            interpolate_level(from_level, to_level, length, position, curve));
    endtask

    // The receiver decides afresh every cycle whether to take a result.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Each word leaving the block is matched against the oldest level owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_levels.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word, level_out %0d", $realtime, level_out);
            end
            else
            begin
                logic signed [LW-1:0] wanted;
                wanted = expected_levels.pop_front();
                if (level_out !== wanted)
                begin
                    error_count++;
                    $display("%0t: level_out expected %0d, actual %0d",
                             $realtime, wanted, level_out);
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d levels outstanding",
                 $realtime, expected_levels.size());
        $display("FAIL envelope_segment_level");
        $finish;
    end

    // A zero-length segment returns the end level whatever the position, and
    // a position past the end is pulled back onto the end.
    task automatic test_zero_length_and_clamp();
        send_word(-32768, 32767, 0, 0, CURVE_LINEAR);
        send_word(32767, -32768, 0, 16'hffff, CURVE_LOG);
        send_word(1234, -4321, 10, 200, CURVE_EXP);
        send_word(-5, 77, 1, 16'hffff, CURVE_LINEAR);
    endtask

    // Full-swing segments of the longest length near the start, middle and end,
    // with every curve code including the unused one; then both ends of a smaller swing and a flat segment.
    task automatic test_curve_extremes();
        logic [CURVE_WIDTH-1:0] curve;
        for (int c = 0; c < 4; c++)
        begin
            curve = CURVE_WIDTH'(c);
            send_word(-32768, 32767, 16'hffff, 16'h8000, curve);
            send_word(32767, -32768, 16'hffff, 16'h0001, curve);
            send_word(-32768, 32767, 16'hffff, 16'hfffe, curve);
        end
        send_word(300, -300, 16'hffff, 0, CURVE_EXP);
        send_word(300, -300, 16'hffff, 16'hffff, CURVE_LOG);
        send_word(-32768, -32768, 16'hffff, 16'h1234, CURVE_LINEAR);
    endtask

    // Exact halves must round away from zero in both directions.
    task automatic test_rounding();
        send_word(0, 1, 2, 1, CURVE_LINEAR);
        send_word(0, -1, 2, 1, CURVE_LINEAR);
        send_word(1, 0, 2, 1, CURVE_LINEAR);
        send_word(0, 3, 2, 1, CURVE_LOG);
        send_word(0, -3, 2, 1, CURVE_EXP);
    endtask

    function automatic logic signed [LW-1:0] pick_level();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return LW'($urandom_range(2) - 1);
            default: return LW'($urandom());
        endcase
    endfunction

    // Mostly short segments, where rounding matters most, with a share of
    // long and zero-length ones.
    function automatic logic [TW-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 50)
            return TW'($urandom_range(16, 1));
        else if (roll < 75)
            return TW'($urandom_range(1024, 17));
        else
            return TW'($urandom_range(65535, 1));
    endfunction

    // Positions fall mostly within the segment, sometimes at its ends and
    // sometimes anywhere in the field, past the end included.
    function automatic logic [TW-1:0] pick_position(input logic [TW-1:0] length);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return TW'($urandom_range(length, 0));
        else if (roll < 72)
            return length;
        else if (roll < 78)
            return '0;
        else
            return TW'($urandom());
    endfunction

    task automatic test_random_traffic(
        input int unsigned words,
        input int unsigned idle_pct,
        input int unsigned stall_pct
    );
        logic [TW-1:0] length;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (words)
        begin
            length = pick_length();
            send_word(pick_level(), pick_level(), length, pick_position(length),
                      CURVE_WIDTH'($urandom_range(3)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        start_level   = '0;
        end_level     = '0;
        segment_ticks = '0;
        tick_position = '0;
        curve_kind    = CURVE_LINEAR;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed words run under light pressure on both sides.
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        test_zero_length_and_clamp();
        test_curve_extremes();
        test_rounding();

        test_random_traffic(PHASE_WORDS, 0, 0);
        test_random_traffic(PHASE_WORDS, 78, 0);
        test_random_traffic(PHASE_WORDS, 0, 78);
        test_random_traffic(PHASE_WORDS, 19, 19);
        in_valid <= 1'b0;

        // Let every owed level drain, then watch a while for stray words.
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS envelope_segment_level");
        else
            $display("FAIL envelope_segment_level");
        $finish;
    end

endmodule
